/* hdl/sncl_pkg.sv */
// ----------------------------------------------------------------------------
// sncl_pkg
// Shared types, constants and helpers of the strip cluster finder.
// ----------------------------------------------------------------------------
package sncl_pkg;

  localparam int CHANNELS_DEF = 128;
  localparam int MAX_OUT      = 64;

  localparam logic [9:0] SEED_CUT_RST      = 10'd48;
  localparam logic [9:0] NEIGHBOUR_CUT_RST = 10'd32;
  localparam logic       POLARITY_RST      = 1'b1;

  localparam logic signed [15:0] ETA_POS_SAT = 16'sh7FFF;
  localparam logic signed [15:0] ETA_NEG_SAT = 16'sh8000;
  localparam logic signed [15:0] ETA_NONE    = -16'sd16384;

  localparam logic signed [31:0] CHARGE_MAX = 32'sd4194303;
  localparam logic signed [31:0] CHARGE_MIN = -32'sd4194304;

  // Quotient width of the eta division: |numerator| * 2^14 stays below 2^30.
  localparam int DIV_NW = 30;
  localparam int DIV_DW = 17;

  typedef enum logic [1:0] {
    REG_SEED_CUT      = 2'd0,
    REG_NEIGHBOUR_CUT = 2'd1,
    REG_POLARITY      = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_CL_RD,
    ST_CL_MUL,
    ST_CL_TEST,
    ST_SO_CHK,
    ST_SO_PREV,
    ST_SO_MUL,
    ST_SO_CMP,
    ST_SO_INS,
    ST_GR_NEXT,
    ST_GR_SEED,
    ST_GR_CHK,
    ST_GL_RD,
    ST_GL_CHK,
    ST_GRR_RD,
    ST_GRR_CHK,
    ST_GR_END,
    ST_ET_LRD,
    ST_ET_LGET,
    ST_ET_RRD,
    ST_ET_RGET,
    ST_ET_SEL,
    ST_ET_DIV,
    ST_ET_FIN,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    state_t op;
    logic   accept_en;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic chan_last;
    logic seed_hit;
    logic j_zero;
    logic higher;
    logic seeds_done;
    logic seed_free;
    logic left_edge;
    logic right_edge;
    logic nb_stop;
    logic rejected;
    logic div_skip;
    logic div_done;
    logic emit_wait;
    logic out_last_slot;
    logic out_free;
  } sts_t;

  // Polarity-corrected signal; negating -32768 needs the 17th bit.
  function automatic logic signed [16:0] corr(input logic signed [15:0] s,
                                              input logic neg);
    logic signed [16:0] sx;
    sx = 17'(s);
    return neg ? -sx : sx;
  endfunction

endpackage

/* hdl/sncl_div.sv */
// ----------------------------------------------------------------------------
// sncl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sncl_div #(
  parameter int NW = 30,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             run;
  logic [CNT_W-1:0] count;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [NW-1:0]    quo;
  logic [DW:0]      rem_sh;
  logic             fits;

  assign rem_sh   = {rem, quo[NW-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        count <= '0;
      end else if (run) begin
        count <= count + 1'b1;
        if (count == CNT_W'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend register shifts left and collects quotient bits at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (run) begin
      rem <= fits ? DW'(rem_sh - {1'b0, dvs}) : rem_sh[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule

/* hdl/sncl_datapath.sv */
// ----------------------------------------------------------------------------
// sncl_datapath
// Channel stores, SNR arithmetic, seed ordering, cluster growth and eta.
// ----------------------------------------------------------------------------
module sncl_datapath #(
  parameter int CHANNELS = sncl_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sncl_pkg::cmd_t      cmd,
  output sncl_pkg::sts_t      sts,
  input  logic                strip_valid,
  input  logic signed [15:0]  signal,
  input  logic [15:0]         noise,
  input  logic                masked,
  input  logic                last_channel,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                cluster_valid,
  output logic [6:0]          cluster_id,
  output logic [6:0]          seed_channel,
  output logic [6:0]          first_channel,
  output logic [7:0]          cluster_size,
  output logic signed [22:0]  charge_sum,
  output logic signed [15:0]  eta,
  output logic                eta_saturated,
  output logic                last
);
  import sncl_pkg::*;

  localparam int CW = $clog2(CHANNELS);
  localparam int NW = CW + 1;
  localparam int AW = CW + 17;

  typedef logic [CW-1:0] idx_t;
  typedef struct packed {
    logic        msk;
    logic [15:0] nz;
    logic [15:0] sig;
  } chan_t;

  chan_t chan_mem [CHANNELS];
  logic  use_mem  [CHANNELS];
  idx_t  order_mem[CHANNELS];
  chan_t chan_rd;
  logic  use_rd;
  idx_t  order_rd;

  logic [9:0] seed_cut;
  logic [9:0] neighbour_cut;
  logic       neg_pol;

  logic [NW-1:0] cnt, n_reg, i_cnt, seed_cnt, j_cnt, k_cnt;
  logic signed [16:0] cur_s, seed_s, l_val, r_val;
  logic [15:0] cur_n;
  logic        cur_m;
  logic signed [33:0] prod_a, prod_b;
  idx_t prev, seed, first, lastc;
  logic signed [AW-1:0] acc;
  logic        rej, lv, rv, q_neg, eta_sat;
  logic signed [15:0] eta_val;
  logic [6:0]  cid, id_cur, outcnt;
  logic        pend_valid;
  logic [6:0]  p_id, p_seed, p_first;
  logic [7:0]  p_size;
  logic signed [22:0] p_charge;
  logic signed [15:0] p_eta;
  logic        p_sat;

  logic        accept, out_free, emit_go, load_out;
  idx_t        i_idx, rd_addr, ord_addr, ord_wdata;
  logic        ord_we, use_we, use_wdata;
  idx_t        use_waddr;
  logic signed [16:0] rd_corr;
  logic signed [33:0] s16;
  logic        usable_now, seed_now, right_edge, seed_right_in;
  logic [25:0] cut_n, cut_s;
  logic        pick_left, none_valid, den_zero, div_skip, div_done;
  logic signed [16:0] num;
  logic signed [17:0] den, den_abs;
  logic [16:0] num_mag;
  logic [DIV_NW-1:0] quo;
  logic signed [31:0] acc32;
  logic signed [22:0] charge_new;
  logic [7:0]  size_new;

  assign accept    = strip_valid && cmd.accept_en;
  assign out_free  = !result_valid || !result_stall;
  assign emit_go   = !(pend_valid && !out_free);
  assign i_idx     = i_cnt[CW-1:0];
  assign rd_corr   = corr(chan_rd.sig, neg_pol);
  assign s16       = 34'(cur_s) <<< 4;
  assign usable_now = !cur_m && !(s16 < prod_a);
  assign seed_now   = usable_now && (s16 > prod_b);
  assign right_edge    = (NW'(lastc) + 1'b1) >= n_reg;
  assign seed_right_in = (NW'(seed) + 1'b1) < n_reg;
  assign cut_n = neighbour_cut * chan_rd.nz;
  assign cut_s = seed_cut * chan_rd.nz;

  // Eta operand selection.
  assign pick_left  = lv && (!rv || (l_val > r_val));
  assign none_valid = !lv && !rv;
  assign num     = pick_left ? l_val : seed_s;
  assign den     = pick_left ? (18'(l_val) + 18'(seed_s)) : (18'(seed_s) + 18'(r_val));
  assign den_abs = den[17] ? -den : den;
  assign num_mag = num[16] ? 17'(-num) : 17'(num);
  assign den_zero = (den == '0);
  assign div_skip = none_valid || den_zero;

  assign acc32      = 32'(acc);
  assign charge_new = (acc32 > CHARGE_MAX) ? 23'(CHARGE_MAX) :
                      (acc32 < CHARGE_MIN) ? 23'(CHARGE_MIN) : 23'(acc32);
  assign size_new   = 8'(NW'(lastc) - NW'(first) + 1'b1);

  sncl_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == ST_ET_SEL && !div_skip),
    .dividend (DIV_NW'(num_mag) << 14),
    .divisor  (den_abs[DIV_DW-1:0]),
    .done     (div_done),
    .quotient (quo)
  );

  // Memory addressing.
  always_comb begin
    case (cmd.op)
      ST_CL_RD:   rd_addr = i_idx;
      ST_SO_PREV: rd_addr = order_rd;
      ST_GR_SEED: rd_addr = order_rd;
      ST_GL_RD:   rd_addr = first - 1'b1;
      ST_GRR_RD:  rd_addr = lastc + 1'b1;
      ST_ET_LRD:  rd_addr = seed - 1'b1;
      ST_ET_RRD:  rd_addr = seed + 1'b1;
      default:    rd_addr = i_idx;
    endcase
    ord_addr  = (cmd.op == ST_GR_NEXT) ? k_cnt[CW-1:0] : CW'(j_cnt - 1'b1);
    ord_we    = (cmd.op == ST_SO_INS) || (cmd.op == ST_SO_CMP && prod_a > prod_b);
    ord_wdata = (cmd.op == ST_SO_INS) ? i_idx : prev;
    use_we    = 1'b0;
    use_waddr = i_idx;
    use_wdata = 1'b0;
    case (cmd.op)
      ST_CL_TEST: begin
        use_we    = 1'b1;
        use_wdata = usable_now;
      end
      ST_GR_CHK: begin
        use_we    = use_rd;
        use_waddr = seed;
      end
      ST_GL_CHK: begin
        use_we    = !chan_rd.msk && use_rd;
        use_waddr = first - 1'b1;
      end
      ST_GRR_CHK: begin
        use_we    = !chan_rd.msk && use_rd;
        use_waddr = lastc + 1'b1;
      end
      default: use_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && cnt < NW'(CHANNELS)) begin
      chan_mem[cnt[CW-1:0]] <= '{msk: masked, nz: noise, sig: signal};
    end
    chan_rd <= chan_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_waddr] <= use_wdata;
    end
    use_rd <= use_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[j_cnt[CW-1:0]] <= ord_wdata;
    end
    order_rd <= order_mem[ord_addr];
  end

  assign load_out = (cmd.op == ST_EMIT && emit_go && pend_valid) ||
                    (cmd.op == ST_FLUSH && out_free);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      seed_cut      <= SEED_CUT_RST;
      neighbour_cut <= NEIGHBOUR_CUT_RST;
      neg_pol       <= POLARITY_RST;
      result_valid  <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SEED_CUT:      seed_cut      <= cfg_data;
          REG_NEIGHBOUR_CUT: neighbour_cut <= cfg_data;
          REG_POLARITY:      neg_pol       <= cfg_data[0];
          default:           ;
        endcase
      end
      if (accept) begin
        if (last_channel) begin
          cnt <= '0;
        end else if (cnt < NW'(CHANNELS)) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.op == ST_EMIT && emit_go) begin
        pend_valid <= 1'b1;
      end else if (cmd.op == ST_FLUSH && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      ST_LOAD: begin
        if (accept && last_channel) begin
          n_reg    <= (cnt < NW'(CHANNELS)) ? cnt + 1'b1 : cnt;
          i_cnt    <= '0;
          seed_cnt <= '0;
          k_cnt    <= '0;
          cid      <= '0;
          outcnt   <= '0;
        end
      end
      ST_CL_MUL: begin
        cur_s  <= rd_corr;
        cur_n  <= chan_rd.nz;
        cur_m  <= chan_rd.msk;
        prod_a <= 34'($signed({1'b0, cut_n}));
        prod_b <= 34'($signed({1'b0, cut_s}));
      end
      ST_CL_TEST: begin
        if (seed_now) begin
          j_cnt <= seed_cnt;
        end else begin
          i_cnt <= i_cnt + 1'b1;
        end
      end
      ST_SO_PREV: prev <= order_rd;
      ST_SO_MUL: begin
        prod_a <= cur_s * $signed({1'b0, chan_rd.nz});
        prod_b <= rd_corr * $signed({1'b0, cur_n});
      end
      ST_SO_CMP: begin
        if (prod_a > prod_b) begin
          j_cnt <= j_cnt - 1'b1;
        end
      end
      ST_SO_INS: begin
        seed_cnt <= seed_cnt + 1'b1;
        i_cnt    <= i_cnt + 1'b1;
      end
      ST_GR_SEED: seed <= order_rd;
      ST_GR_CHK: begin
        if (use_rd) begin
          first  <= seed;
          lastc  <= seed;
          acc    <= AW'(rd_corr);
          seed_s <= rd_corr;
          rej    <= 1'b0;
          id_cur <= cid;
          cid    <= cid + 1'b1;
        end else begin
          k_cnt <= k_cnt + 1'b1;
        end
      end
      ST_GL_RD: begin
        if (first == '0) begin
          rej <= 1'b1;
        end
      end
      ST_GL_CHK: begin
        if (chan_rd.msk) begin
          rej <= 1'b1;
        end else if (use_rd) begin
          first <= first - 1'b1;
          acc   <= acc + AW'(rd_corr);
        end
      end
      ST_GRR_RD: begin
        if (right_edge) begin
          rej <= 1'b1;
        end
      end
      ST_GRR_CHK: begin
        if (chan_rd.msk) begin
          rej <= 1'b1;
        end else if (use_rd) begin
          lastc <= lastc + 1'b1;
          acc   <= acc + AW'(rd_corr);
        end
      end
      ST_GR_END: begin
        if (rej) begin
          k_cnt <= k_cnt + 1'b1;
        end
      end
      ST_ET_LGET: begin
        lv    <= (seed != '0) && !chan_rd.msk;
        l_val <= rd_corr;
      end
      ST_ET_RGET: begin
        rv    <= seed_right_in && !chan_rd.msk;
        r_val <= rd_corr;
      end
      ST_ET_SEL: begin
        q_neg <= num[16] ^ den[17];
        if (none_valid) begin
          eta_val <= ETA_NONE;
          eta_sat <= 1'b0;
        end else if (den_zero) begin
          eta_sat <= 1'b1;
          eta_val <= num[16] ? ETA_NEG_SAT : ((num != '0) ? ETA_POS_SAT : '0);
        end
      end
      ST_ET_FIN: begin
        if (!q_neg) begin
          eta_sat <= quo > DIV_NW'(32767);
          eta_val <= (quo > DIV_NW'(32767)) ? ETA_POS_SAT : 16'(quo);
        end else begin
          eta_sat <= quo > DIV_NW'(32768);
          eta_val <= (quo > DIV_NW'(32768)) ? ETA_NEG_SAT : 16'(17'(0) - quo[16:0]);
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (pend_valid) begin
            cluster_valid <= 1'b1;
            cluster_id    <= p_id;
            seed_channel  <= p_seed;
            first_channel <= p_first;
            cluster_size  <= p_size;
            charge_sum    <= p_charge;
            eta           <= p_eta;
            eta_saturated <= p_sat;
            last          <= 1'b0;
          end
          p_id     <= id_cur;
          p_seed   <= 7'(seed);
          p_first  <= 7'(first);
          p_size   <= size_new;
          p_charge <= charge_new;
          p_eta    <= eta_val;
          p_sat    <= eta_sat;
          outcnt   <= outcnt + 1'b1;
          k_cnt    <= k_cnt + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          cluster_valid <= pend_valid;
          cluster_id    <= pend_valid ? p_id : '0;
          seed_channel  <= pend_valid ? p_seed : '0;
          first_channel <= pend_valid ? p_first : '0;
          cluster_size  <= pend_valid ? p_size : '0;
          charge_sum    <= pend_valid ? p_charge : '0;
          eta           <= pend_valid ? p_eta : '0;
          eta_saturated <= pend_valid ? p_sat : 1'b0;
          last          <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.frame_end     = accept && last_channel;
    sts.chan_last     = (i_cnt + 1'b1) == n_reg;
    sts.seed_hit      = seed_now;
    sts.j_zero        = (j_cnt == '0);
    sts.higher        = prod_a > prod_b;
    sts.seeds_done    = (k_cnt == seed_cnt);
    sts.seed_free     = use_rd;
    sts.left_edge     = (first == '0);
    sts.right_edge    = right_edge;
    sts.nb_stop       = chan_rd.msk || !use_rd;
    sts.rejected      = rej;
    sts.div_skip      = div_skip;
    sts.div_done      = div_done;
    sts.emit_wait     = !emit_go;
    sts.out_last_slot = (outcnt == 7'(MAX_OUT - 1));
    sts.out_free      = out_free;
  end

endmodule

/* hdl/sncl_ctrl.sv */
// ----------------------------------------------------------------------------
// sncl_ctrl
// Sequencer for loading, classification, seed ordering, growth, eta and output.
// ----------------------------------------------------------------------------
module sncl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  sncl_pkg::sts_t sts,
  output sncl_pkg::cmd_t cmd
);
  import sncl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:    if (sts.frame_end) state_next = ST_CL_RD;
      ST_CL_RD:   state_next = ST_CL_MUL;
      ST_CL_MUL:  state_next = ST_CL_TEST;
      ST_CL_TEST: begin
        if (sts.seed_hit) begin
          state_next = ST_SO_CHK;
        end else begin
          state_next = sts.chan_last ? ST_GR_NEXT : ST_CL_RD;
        end
      end
      ST_SO_CHK:  state_next = sts.j_zero ? ST_SO_INS : ST_SO_PREV;
      ST_SO_PREV: state_next = ST_SO_MUL;
      ST_SO_MUL:  state_next = ST_SO_CMP;
      ST_SO_CMP:  state_next = sts.higher ? ST_SO_CHK : ST_SO_INS;
      ST_SO_INS:  state_next = sts.chan_last ? ST_GR_NEXT : ST_CL_RD;
      ST_GR_NEXT: state_next = sts.seeds_done ? ST_FLUSH : ST_GR_SEED;
      ST_GR_SEED: state_next = ST_GR_CHK;
      ST_GR_CHK:  state_next = sts.seed_free ? ST_GL_RD : ST_GR_NEXT;
      ST_GL_RD:   state_next = sts.left_edge ? ST_GRR_RD : ST_GL_CHK;
      ST_GL_CHK:  state_next = sts.nb_stop ? ST_GRR_RD : ST_GL_RD;
      ST_GRR_RD:  state_next = sts.right_edge ? ST_GR_END : ST_GRR_CHK;
      ST_GRR_CHK: state_next = sts.nb_stop ? ST_GR_END : ST_GRR_RD;
      ST_GR_END:  state_next = sts.rejected ? ST_GR_NEXT : ST_ET_LRD;
      ST_ET_LRD:  state_next = ST_ET_LGET;
      ST_ET_LGET: state_next = ST_ET_RRD;
      ST_ET_RRD:  state_next = ST_ET_RGET;
      ST_ET_RGET: state_next = ST_ET_SEL;
      ST_ET_SEL:  state_next = sts.div_skip ? ST_EMIT : ST_ET_DIV;
      ST_ET_DIV:  if (sts.div_done) state_next = ST_ET_FIN;
      ST_ET_FIN:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (!sts.emit_wait) begin
          state_next = sts.out_last_slot ? ST_FLUSH : ST_GR_NEXT;
        end
      end
      ST_FLUSH:   if (sts.out_free) state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd.op        = state;
    cmd.accept_en = (state == ST_LOAD);
  end

endmodule

/* hdl/strip_seed_neighbour_clustering.sv */
// ----------------------------------------------------------------------------
// strip_seed_neighbour_clustering
// Seed/neighbour cluster finder for one frame of silicon strip channels.
// ----------------------------------------------------------------------------
// Channels are taken one per cycle while the block is loading. The channel
// flagged last_channel closes the frame; the block then stalls its input
// while it classifies each channel (read, multiply, test), insertion-sorts
// the seeds (check, read previous, multiply, compare per position a seed
// moves), grows each cluster (a read and a check per channel touched) and
// computes eta for each accepted cluster with a one-bit-per-cycle divider.
// Results leave through an output register, so the next frame can load
// while the final result still waits. A frame with no accepted cluster
// gives one result with cluster_valid low and last high.
module strip_seed_neighbour_clustering #(
  parameter int CHANNELS = sncl_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               strip_valid,
  output logic               strip_stall,
  input  logic signed [15:0] signal,
  input  logic [15:0]        noise,
  input  logic               masked,
  input  logic               last_channel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               cluster_valid,
  output logic [6:0]         cluster_id,
  output logic [6:0]         seed_channel,
  output logic [6:0]         first_channel,
  output logic [7:0]         cluster_size,
  output logic signed [22:0] charge_sum,
  output logic signed [15:0] eta,
  output logic               eta_saturated,
  output logic               last
);
  import sncl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign strip_stall = !cmd.accept_en;
  assign cfg_ready   = 1'b1;

  sncl_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  sncl_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .strip_valid   (strip_valid),
    .signal        (signal),
    .noise         (noise),
    .masked        (masked),
    .last_channel  (last_channel),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .cluster_valid (cluster_valid),
    .cluster_id    (cluster_id),
    .seed_channel  (seed_channel),
    .first_channel (first_channel),
    .cluster_size  (cluster_size),
    .charge_sum    (charge_sum),
    .eta           (eta),
    .eta_saturated (eta_saturated),
    .last          (last)
  );

endmodule

/* hdl/sncl_checker.sv */
// ----------------------------------------------------------------------------
// sncl_checker
// Port-level checks of the cluster finder's result channel.
// ----------------------------------------------------------------------------
module sncl_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic               cluster_valid,
  input logic [6:0]         cluster_id,
  input logic [7:0]         cluster_size,
  input logic signed [22:0] charge_sum,
  input logic signed [15:0] eta,
  input logic               eta_saturated,
  input logic               last
);

  // A held result transaction keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(cluster_id) &&
      $stable(charge_sum) && $stable(eta) && $stable(last))
    else $error("result changed while stalled");

  // The empty-frame marker is always the final result and carries zeros.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !cluster_valid |-> last && cluster_id == 7'd0 &&
      cluster_size == 8'd0 && charge_sum == 23'sd0 && eta == 16'sd0 && !eta_saturated)
    else $error("malformed empty-frame result");

  a_size: assert property (@(posedge clk) disable iff (rst)
    result_valid && cluster_valid |-> cluster_size != 8'd0)
    else $error("accepted cluster with zero size");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && eta_saturated |->
      eta == 16'sh7FFF || eta == 16'sh8000 || eta == 16'sd0)
    else $error("saturated eta not at a limit");

endmodule

bind strip_seed_neighbour_clustering sncl_checker u_sncl_checker (.*);

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Strip cluster finder testbench
// Loads frames of strip channels with random pacing and checks every cluster
// result against a behavioral cluster search kept inside the testbench.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sncl_pkg::*;

  localparam int NCH = 128;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [15:0] signal;
    logic [15:0]        noise;
    logic               masked;
    logic               last_channel;
  } strip_t;

  typedef struct packed {
    logic               cluster_valid;
    logic [6:0]         cluster_id;
    logic [6:0]         seed_channel;
    logic [6:0]         first_channel;
    logic [7:0]         cluster_size;
    logic signed [22:0] charge_sum;
    logic signed [15:0] eta;
    logic               eta_saturated;
    logic               last;
  } cluster_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic strip_valid = 1'b0;
  logic strip_stall;
  logic signed [15:0] signal = '0;
  logic [15:0] noise = 16'd1;
  logic masked = 1'b0;
  logic last_channel = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  cluster_t got;

  strip_seed_neighbour_clustering u_top (
    .clk, .rst, .strip_valid, .strip_stall, .signal, .noise, .masked,
    .last_channel, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .result_valid, .result_stall,
    .cluster_valid(got.cluster_valid), .cluster_id(got.cluster_id),
    .seed_channel(got.seed_channel), .first_channel(got.first_channel),
    .cluster_size(got.cluster_size), .charge_sum(got.charge_sum),
    .eta(got.eta), .eta_saturated(got.eta_saturated), .last(got.last)
  );

  always #1 clk = ~clk;

  strip_t   pending_strips[$];
  cluster_t expected_clusters[$];
  int       errors = 0;
  longint   cycles = 0;
  int       items_sent = 0;
  int       items_queued = 0;

  // Predictor state.
  logic [9:0] p_seed_cut = SEED_CUT_RST;
  logic [9:0] p_nb_cut = NEIGHBOUR_CUT_RST;
  logic       p_neg = POLARITY_RST;
  longint     f_sig[NCH];
  longint     f_noise[NCH];
  bit         f_mask[NCH];
  int         f_count = 0;

  function automatic longint corrected_of(int ch);
    return p_neg ? -f_sig[ch] : f_sig[ch];
  endfunction

  function automatic void add_strip(strip_t s);
    pending_strips.insert(pending_strips.size(), s);
    items_queued++;
  endfunction

  // Accepts one channel and, at frame end, queues the clusters it yields.
  function automatic void predict_clusters(strip_t s);
    bit usable[NCH];
    int order[NCH];
    int nseeds, n, j, nout, next_id, seed, lo, hi;
    bit rej, lv, rv;
    longint sx16, q, chg, l, r, sv, num, den;
    cluster_t c;
    if (f_count < NCH) begin
      f_sig[f_count] = s.signal;
      f_noise[f_count] = s.noise;
      f_mask[f_count] = s.masked;
      f_count++;
    end
    if (!s.last_channel) return;
    n = f_count;
    f_count = 0;
    nseeds = 0;
    nout = 0;
    next_id = 0;
    for (int i = 0; i < n; i++) begin
      sx16 = corrected_of(i) * 16;
      usable[i] = !f_mask[i];
      if (!usable[i]) continue;
      if (sx16 < longint'(p_nb_cut) * f_noise[i]) usable[i] = 0;
      else if (sx16 > longint'(p_seed_cut) * f_noise[i]) begin
        j = nseeds;
        while (j > 0 && corrected_of(i) * f_noise[order[j-1]] >
                        corrected_of(order[j-1]) * f_noise[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        nseeds++;
      end
    end
    for (int k = 0; k < nseeds && nout < MAX_OUT; k++) begin
      seed = order[k];
      if (!usable[seed]) continue;
      c = '0;
      c.cluster_id = next_id[6:0];
      next_id++;
      usable[seed] = 0;
      chg = corrected_of(seed);
      lo = seed;
      hi = seed;
      rej = 0;
      forever begin
        if (lo == 0 || f_mask[lo-1]) begin rej = 1; break; end
        if (!usable[lo-1]) break;
        lo--;
        usable[lo] = 0;
        chg += corrected_of(lo);
      end
      forever begin
        if (hi + 1 >= n || f_mask[hi+1]) begin rej = 1; break; end
        if (!usable[hi+1]) break;
        hi++;
        usable[hi] = 0;
        chg += corrected_of(hi);
      end
      if (rej) continue;
      if (chg > 4194303) chg = 4194303;
      if (chg < -4194304) chg = -4194304;
      sv = corrected_of(seed);
      lv = seed > 0 && !f_mask[seed-1];
      rv = seed + 1 < n && !f_mask[seed+1];
      l = lv ? corrected_of(seed-1) : 0;
      r = rv ? corrected_of(seed+1) : 0;
      if (!lv && !rv) c.eta = ETA_NONE;
      else begin
        if (lv && (!rv || l > r)) begin num = l; den = l + sv; end
        else begin num = sv; den = sv + r; end
        if (den == 0) begin
          c.eta_saturated = 1;
          c.eta = num > 0 ? ETA_POS_SAT : (num < 0 ? ETA_NEG_SAT : 16'sd0);
        end else begin
          q = (num * 16384) / den;
          if (q > 32767) begin q = 32767; c.eta_saturated = 1; end
          if (q < -32768) begin q = -32768; c.eta_saturated = 1; end
          c.eta = q[15:0];
        end
      end
      c.cluster_valid = 1;
      c.seed_channel = seed[6:0];
      c.first_channel = lo[6:0];
      c.cluster_size = 8'(hi - lo + 1);
      c.charge_sum = chg[22:0];
      expected_clusters.insert(expected_clusters.size(), c);
      nout++;
    end
    if (nout == 0) begin
      c = '0;
      c.last = 1;
      expected_clusters.insert(expected_clusters.size(), c);
    end else expected_clusters[$].last = 1;
  endfunction

  // Driver.
  int strip_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (strip_valid && !strip_stall) begin
        predict_clusters('{signal, noise, masked, last_channel});
        items_sent++;
      end
      if (!strip_valid || !strip_stall) begin
        if (strip_gap > 0 || pending_strips.size() == 0) begin
          strip_valid <= 1'b0;
          if (strip_gap > 0) strip_gap <= strip_gap - 1;
        end else begin
          {signal, noise, masked, last_channel} <= pending_strips.pop_front();
          strip_valid <= 1'b1;
          strip_gap <= $urandom_range(0, 6) * ($urandom_range(0, 3) == 0);
        end
      end
    end
  end

  // Monitor.
  int res_gap = 0;
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_clusters.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result %p", got);
        end else begin
          cluster_t e;
          e = expected_clusters.pop_front();
          if (e !== got) begin
            errors++;
            if (errors <= 10) $display("Mismatch: expected %p, got %p", e, got);
          end
        end
      end
      if (res_gap > 0) begin
        result_stall <= 1'b1;
        res_gap <= res_gap - 1;
      end else begin
        result_stall <= 1'b0;
        res_gap <= $urandom_range(0, 6) * ($urandom_range(0, 2) == 0);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [9:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SEED_CUT:      p_seed_cut = val;
      REG_NEIGHBOUR_CUT: p_nb_cut = val;
      default:           p_neg = val[0];
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_strips.size() != 0 || strip_valid || expected_clusters.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic strip_t rand_strip(int sigscale, bit lastc);
    strip_t s;
    int pick;
    pick = $urandom_range(0, 9);
    s.noise = (pick == 0) ? 16'($urandom) : 16'($urandom_range(8, 40));
    if (pick == 1) s.noise = 16'd0;
    if (pick == 2) s.signal = 16'($urandom);
    else s.signal = 16'(($urandom_range(0, 2) == 0 ? 1 : -1) *
                        int'($urandom_range(0, sigscale)));
    s.masked = ($urandom_range(0, 11) == 0);
    s.last_channel = lastc;
    return s;
  endfunction

  // Random frame; mostly short, sometimes near full length or overlong.
  task automatic push_frame();
    int len, pick;
    pick = $urandom_range(0, 19);
    len = pick == 0 ? $urandom_range(120, 140) : $urandom_range(1, 24);
    for (int i = 0; i < len; i++)
      add_strip(rand_strip(pick < 2 ? 32767 : 600, i == len - 1));
  endtask

  initial begin
    strip_t s;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes of the fields, rejection at edges and masks.
    add_strip('{-16'sd32768, 16'd65535, 1'b0, 1'b0});
    add_strip('{16'sd32767, 16'd1, 1'b0, 1'b0});
    add_strip('{-16'sd400, 16'd10, 1'b0, 1'b0});
    add_strip('{-16'sd900, 16'd10, 1'b0, 1'b0});
    add_strip('{-16'sd400, 16'd10, 1'b0, 1'b0});
    add_strip('{16'sd0, 16'd0, 1'b0, 1'b0});
    add_strip('{-16'sd900, 16'd10, 1'b1, 1'b0});
    add_strip('{-16'sd900, 16'd10, 1'b0, 1'b0});
    add_strip('{16'sd0, 16'd10, 1'b0, 1'b1});
    add_strip('{-16'sd900, 16'd10, 1'b0, 1'b1});
    for (int i = 0; i < 5; i++)
      add_strip('{(i == 2) ? -16'sd800 : 16'sd800, 16'd10, 1'b0, i == 4});
    wait_idle();
    write_reg(REG_SEED_CUT, 10'd0);
    write_reg(REG_NEIGHBOUR_CUT, 10'd0);
    write_reg(REG_POLARITY, 1'b0);
    // Many small clusters in an overlong frame: close to the result limit.
    for (int i = 0; i < 130; i++)
      add_strip('{(i % 2) ? 16'sd500 : -16'sd500, 16'd1, 1'b0, i == 129});
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin write_reg(REG_SEED_CUT, 10'd1023); write_reg(REG_NEIGHBOUR_CUT, 10'd1023); end
        1: begin write_reg(REG_SEED_CUT, 10'd48); write_reg(REG_NEIGHBOUR_CUT, 10'd32);
                 write_reg(REG_POLARITY, 1'b1); end
        default: begin
          write_reg(REG_SEED_CUT, 10'($urandom_range(0, 120)));
          write_reg(REG_NEIGHBOUR_CUT, 10'($urandom_range(0, 60)));
          write_reg(REG_POLARITY, 1'($urandom));
        end
      endcase
      while (items_queued < 145 + 50 * (ph + 1)) push_frame();
    end
    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_clusters.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
hdl/sncl_pkg.sv
hdl/sncl_div.sv
hdl/sncl_datapath.sv
hdl/sncl_ctrl.sv
hdl/strip_seed_neighbour_clustering.sv
hdl/sncl_checker.sv
test/testbench.sv
